// ===== hdl/aksd_pkg.sv =====
// shared types, constants and helpers of the auto-calibrating key detector
// depends on nothing; used by aksd_trigger_calc, aksd_result_fifo and the top level

package aksd_pkg;

    // fixed field widths
    localparam int IDX_W      = 4;
    localparam int LEVEL_W    = 16;
    localparam int PERMILLE_W = 10;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // defaults of the top level parameters
    localparam int DEFAULT_SENSOR_COUNT = 16;
    localparam int DEFAULT_SAMPLE_BITS  = 16;

    // register reset values
    localparam logic [PERMILLE_W-1:0] THRESHOLD_RESET  = 10'd700;
    localparam logic [PERMILLE_W-1:0] HYSTERESIS_RESET = 10'd120;
    localparam logic [LEVEL_W-1:0]    MIN_SPAN_RESET   = 16'd500;

    // full scale of a permille level
    localparam logic [PERMILLE_W-1:0] PERMILLE_FULL = 10'd1000;

    // floor(p / 1000) as (p * DIV_RECIP) >> DIV_SHIFT, exact for p below 2**26
    localparam int PROD_W    = LEVEL_W + PERMILLE_W;
    localparam int RECIP_W   = 27;
    localparam int DIV_SHIFT = 36;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719477;

    // results buffered between the trigger pipe and the output channel
    localparam int RESULT_DEPTH = 8;

    // register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_HYSTERESIS = 2'd1,
        REG_MIN_SPAN   = 2'd2
    } cfg_reg_e;

    // request payload
    typedef struct packed {
        logic [IDX_W-1:0]   sensor_index;
        logic [LEVEL_W-1:0] raw_sample;
    } sample_t;

    // result payload
    typedef struct packed {
        logic [IDX_W-1:0]   sensor_id;
        logic               key_down;
        logic               press_event;
        logic               release_event;
        logic               calibrated;
        logic [LEVEL_W-1:0] low_trigger;
        logic [LEVEL_W-1:0] high_trigger;
    } result_t;

    // switching levels in permille
    typedef struct packed {
        logic [PERMILLE_W-1:0] lo;
        logic [PERMILLE_W-1:0] hi;
    } ppm_pair_t;

    // decision of the state loop, handed to the trigger pipe
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   sensor_id;
        logic               key_down;
        logic               press_event;
        logic               release_event;
        logic               calibrated;
        logic [LEVEL_W-1:0] level_min;
        logic [LEVEL_W-1:0] level_max;
        logic [LEVEL_W-1:0] span;
    } judge_t;

    // threshold minus and plus half the hysteresis, clamped to 0..1000
    function automatic ppm_pair_t ppm_levels(input logic [PERMILLE_W-1:0] thr,
                                             input logic [PERMILLE_W-1:0] hyst);
        logic [PERMILLE_W-1:0] half;
        logic [PERMILLE_W-1:0] lo_diff;
        logic [PERMILLE_W:0]   hi_sum;
        ppm_pair_t             r;
        half    = hyst >> 1;
        lo_diff = (thr > half) ? (thr - half) : '0;
        hi_sum  = {1'b0, thr} + {1'b0, half};
        r.lo    = (lo_diff > PERMILLE_FULL) ? PERMILLE_FULL : lo_diff;
        r.hi    = (hi_sum > {1'b0, PERMILLE_FULL}) ? PERMILLE_FULL : hi_sum[PERMILLE_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/aksd_stream_if.sv =====
// valid/ready stream channel carrying one payload per request
// depends on nothing; payload type set by the instantiating level

interface aksd_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/aksd_trigger_calc.sv =====
// trigger level pipe: span times permille, divide by 1000, add observed min
// depends on aksd_pkg

module aksd_trigger_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  aksd_pkg::judge_t    judge,
    input  aksd_pkg::ppm_pair_t ppm,
    output logic                push,
    output aksd_pkg::result_t   push_data
);

    localparam int PW = aksd_pkg::PROD_W;
    localparam int RW = aksd_pkg::RECIP_W;
    localparam int LW = aksd_pkg::LEVEL_W;

    aksd_pkg::judge_t s1_judge_reg;
    aksd_pkg::judge_t s2_judge_reg;
    logic [PW-1:0]    p_lo_reg;
    logic [PW-1:0]    p_hi_reg;
    logic [PW-1:0]    p_lo_next;
    logic [PW-1:0]    p_hi_next;
    logic [LW-1:0]    q_lo_reg;
    logic [LW-1:0]    q_hi_reg;
    logic [PW+RW-1:0] qx_lo;
    logic [PW+RW-1:0] qx_hi;

    // stage 1: span times both permille levels
    always_comb
    begin
        p_lo_next = {{aksd_pkg::PERMILLE_W{1'b0}}, judge.span}
                  * {{LW{1'b0}}, ppm.lo};
        p_hi_next = {{aksd_pkg::PERMILLE_W{1'b0}}, judge.span}
                  * {{LW{1'b0}}, ppm.hi};
    end

    // stage 2: divide by 1000 through the reciprocal
    always_comb
    begin
        qx_lo = {{RW{1'b0}}, p_lo_reg} * {{PW{1'b0}}, aksd_pkg::DIV_RECIP};
        qx_hi = {{RW{1'b0}}, p_hi_reg} * {{PW{1'b0}}, aksd_pkg::DIV_RECIP};
    end

    // control of the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_judge_reg <= '0;
            s2_judge_reg <= '0;
        end
        else
        begin
            s1_judge_reg <= judge;
            s2_judge_reg <= s1_judge_reg;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        p_lo_reg <= p_lo_next;
        p_hi_reg <= p_hi_next;
        q_lo_reg <= qx_lo[aksd_pkg::DIV_SHIFT +: LW];
        q_hi_reg <= qx_hi[aksd_pkg::DIV_SHIFT +: LW];
    end

    // stage 3: add the observed min, or pass min/max while uncalibrated
    always_comb
    begin
        push                    = s2_judge_reg.valid;
        push_data.sensor_id     = s2_judge_reg.sensor_id;
        push_data.key_down      = s2_judge_reg.key_down;
        push_data.press_event   = s2_judge_reg.press_event;
        push_data.release_event = s2_judge_reg.release_event;
        push_data.calibrated    = s2_judge_reg.calibrated;
        if (s2_judge_reg.calibrated)
        begin
            push_data.low_trigger  = s2_judge_reg.level_min + q_lo_reg;
            push_data.high_trigger = s2_judge_reg.level_min + q_hi_reg;
        end
        else
        begin
            push_data.low_trigger  = s2_judge_reg.level_min;
            push_data.high_trigger = s2_judge_reg.level_max;
        end
    end

endmodule

// ===== hdl/aksd_result_fifo.sv =====
// small result buffer between the trigger pipe and the output channel
// depends on aksd_pkg

module aksd_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  aksd_pkg::result_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output aksd_pkg::result_t pop_data
);

    localparam int DEPTH = aksd_pkg::RESULT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    aksd_pkg::result_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;

    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // upstream credit keeps the buffer from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(DEPTH)))
        else $error("result buffer written while full");

endmodule

// ===== hdl/autocal_key_schmitt_detector.sv =====
// Auto-calibrating Schmitt-trigger key detector for a bank of hall sensors.
// Requests on "samples" carry a sensor index and a raw sample; each request
// gives exactly one result on "results", in request order: key state, press
// and release events, calibration flag and the two trigger levels.
// Per-sensor min, max, last sample and pressed bit live in one synchronous
// memory; a read-modify-write loop with forwarding of the previous write
// lets requests for any sensors, the same one included, enter one per
// cycle while samples.ready is high. A request passes memory read, state
// loop, product, reciprocal divide and result buffer, in that order.
// Throughput: one request per cycle while results are taken.
// Up to 8 requests may be outstanding; when the receiver stalls, results
// queue in an 8-entry buffer and samples.ready drops once 8 are pending.
// Reset clears per-sensor valid bits, so every sensor reads as released with
// min all ones and max zero at once; no clearing pass is needed.
// Registers over APB at 0x0 threshold, 0x4 hysteresis, 0x8 min span; write
// them only while no request is outstanding.
// depends on aksd_pkg, aksd_stream_if, aksd_trigger_calc, aksd_result_fifo

module autocal_key_schmitt_detector #(
    parameter int SENSOR_COUNT = aksd_pkg::DEFAULT_SENSOR_COUNT,
    parameter int SAMPLE_BITS  = aksd_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    aksd_stream_if.sink                   samples,
    aksd_stream_if.source                 results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aksd_pkg::PADDR_W-1:0]  paddr,
    input  logic [aksd_pkg::PDATA_W-1:0]  pwdata,
    output logic [aksd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int SB     = SAMPLE_BITS;
    localparam int ADDR_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int WORD_W = 3 * SB + 1;
    localparam int LOOP_W = SB + aksd_pkg::PERMILLE_W;
    localparam int LW     = aksd_pkg::LEVEL_W;
    localparam int PMW    = aksd_pkg::PERMILLE_W;
    localparam int DEPTH  = aksd_pkg::RESULT_DEPTH;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // word layout: pressed, last, max, min
    localparam logic [WORD_W-1:0] RESET_WORD = {1'b0, {SB{1'b0}}, {SB{1'b0}}, {SB{1'b1}}};

    // configuration
    logic [PMW-1:0]      threshold_reg;
    logic [PMW-1:0]      hysteresis_reg;
    logic [LW-1:0]       min_span_reg;
    logic                cfg_we;
    aksd_pkg::ppm_pair_t ppm;

    // request side
    logic              in_fire;
    logic              out_fire;
    logic [ADDR_W-1:0] in_addr;
    logic [CNT_W-1:0]  outstanding_reg;
    logic [CNT_W-1:0]  outstanding_next;

    // state memory and per-entry valid bits
    logic [WORD_W-1:0]       state_mem [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] entry_valid_reg;
    logic [WORD_W-1:0]       rd_word_reg;
    logic                    rd_init_reg;

    // state loop stage
    logic                     e_valid_reg;
    logic [aksd_pkg::IDX_W-1:0] e_idx_reg;
    logic [SB-1:0]            e_raw_reg;
    logic [ADDR_W-1:0]        e_addr_reg;
    logic                     e_oor_reg;
    logic [WORD_W-1:0]        cur_word;
    logic [SB-1:0]            cur_min;
    logic [SB-1:0]            cur_max;
    logic [SB-1:0]            cur_last;
    logic                     cur_pressed;
    logic [SB-1:0]            new_min;
    logic [SB-1:0]            new_max;
    logic [SB-1:0]            span_sb;
    logic                     span_ok;
    logic                     raw_below;
    logic [PMW-1:0]           ppm_sel;
    logic [LOOP_W-1:0]        loop_prod;
    logic [LOOP_W-1:0]        dist_k;
    logic                     press_hit;
    logic                     release_hit;
    logic                     down;
    logic                     wb_en;
    logic [WORD_W-1:0]        wb_word;

    // forwarding of the last write
    logic              wb_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic [WORD_W-1:0] wb_word_reg;

    // handoff to the trigger pipe
    aksd_pkg::judge_t  judge_reg;
    aksd_pkg::judge_t  judge_next;
    logic              push;
    aksd_pkg::result_t push_data;

    // apb access
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= aksd_pkg::THRESHOLD_RESET;
            hysteresis_reg <= aksd_pkg::HYSTERESIS_RESET;
            min_span_reg   <= aksd_pkg::MIN_SPAN_RESET;
        end
        else if (cfg_we)
        begin
            case (aksd_pkg::cfg_reg_e'(paddr[3:2]))
                aksd_pkg::REG_THRESHOLD:  threshold_reg  <= pwdata[PMW-1:0];
                aksd_pkg::REG_HYSTERESIS: hysteresis_reg <= pwdata[PMW-1:0];
                aksd_pkg::REG_MIN_SPAN:   min_span_reg   <= pwdata[LW-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (aksd_pkg::cfg_reg_e'(paddr[3:2]))
            aksd_pkg::REG_THRESHOLD:  prdata = aksd_pkg::PDATA_W'(threshold_reg);
            aksd_pkg::REG_HYSTERESIS: prdata = aksd_pkg::PDATA_W'(hysteresis_reg);
            aksd_pkg::REG_MIN_SPAN:   prdata = aksd_pkg::PDATA_W'(min_span_reg);
            default:                  prdata = '0;
        endcase
    end

    assign ppm = aksd_pkg::ppm_levels(threshold_reg, hysteresis_reg);

    // request credit: accepted minus delivered
    assign in_fire       = samples.valid && samples.ready;
    assign out_fire      = results.valid && results.ready;
    assign samples.ready = (outstanding_reg < CNT_W'(DEPTH));
    assign in_addr       = ADDR_W'(samples.payload.sensor_index);

    always_comb
    begin
        outstanding_next = outstanding_reg + CNT_W'(in_fire) - CNT_W'(out_fire);
    end

    // memory: write back from the loop stage, read on accept
    always_ff @(posedge clk)
    begin
        if (wb_en)
        begin
            state_mem[e_addr_reg] <= wb_word;
        end
        if (in_fire)
        begin
            rd_word_reg <= state_mem[in_addr];
            rd_init_reg <= entry_valid_reg[in_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            entry_valid_reg <= '0;
            e_valid_reg     <= 1'b0;
            wb_valid_reg    <= 1'b0;
            judge_reg       <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
            if (wb_en)
            begin
                entry_valid_reg[e_addr_reg] <= 1'b1;
            end
            e_valid_reg  <= in_fire;
            wb_valid_reg <= wb_en;
            judge_reg    <= judge_next;
        end
    end

    // request fields and last write, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            e_idx_reg  <= samples.payload.sensor_index;
            e_raw_reg  <= samples.payload.raw_sample[SB-1:0];
            e_addr_reg <= in_addr;
            e_oor_reg  <= !(int'(samples.payload.sensor_index) < SENSOR_COUNT);
        end
        wb_addr_reg <= e_addr_reg;
        wb_word_reg <= wb_word;
    end

    // current state: forwarded write, stored word or reset value
    always_comb
    begin
        cur_word = rd_init_reg ? rd_word_reg : RESET_WORD;
        if (wb_valid_reg && (wb_addr_reg == e_addr_reg))
        begin
            cur_word = wb_word_reg;
        end
        cur_min     = cur_word[SB-1:0];
        cur_max     = cur_word[2*SB-1:SB];
        cur_last    = cur_word[3*SB-1:2*SB];
        cur_pressed = cur_word[3*SB];
    end

    // calibration and schmitt decision
    always_comb
    begin
        new_min = (!cur_pressed && (e_raw_reg < cur_min)) ? e_raw_reg : cur_min;
        new_max = (!cur_pressed && (e_raw_reg > cur_max)) ? e_raw_reg : cur_max;
        span_sb = new_max - new_min;
        span_ok = (new_max > new_min) && (LW'(span_sb) >= min_span_reg);

        // only the level facing the current state matters for the decision
        ppm_sel   = cur_pressed ? ppm.lo : ppm.hi;
        loop_prod = {{PMW{1'b0}}, span_sb} * {{SB{1'b0}}, ppm_sel};
        raw_below = (e_raw_reg < new_min);
        dist_k    = {{PMW{1'b0}}, e_raw_reg - new_min} * LOOP_W'(aksd_pkg::PERMILLE_FULL);

        // raw >= min + floor(p/1000)  <=>  p < (raw - min) * 1000 + 1000
        press_hit   = !raw_below
                   && (loop_prod < (dist_k + LOOP_W'(aksd_pkg::PERMILLE_FULL)))
                   && (e_raw_reg > cur_last);
        // raw <= min + floor(p/1000)  <=>  (raw - min) * 1000 <= p
        release_hit = (raw_below || (dist_k <= loop_prod)) && (e_raw_reg < cur_last);

        if (!span_ok)
        begin
            down = 1'b0;
        end
        else if (!cur_pressed && press_hit)
        begin
            down = 1'b1;
        end
        else if (cur_pressed && release_hit)
        begin
            down = 1'b0;
        end
        else
        begin
            down = cur_pressed;
        end

        wb_en   = e_valid_reg && !e_oor_reg;
        wb_word = {down, e_raw_reg, new_max, new_min};
    end

    // decision record; an unknown sensor gives zeros
    always_comb
    begin
        judge_next           = '0;
        judge_next.valid     = e_valid_reg;
        judge_next.sensor_id = e_idx_reg;
        if (!e_oor_reg)
        begin
            judge_next.key_down      = down;
            judge_next.press_event   = !cur_pressed && down;
            judge_next.release_event = cur_pressed && !down;
            judge_next.calibrated    = span_ok;
            judge_next.level_min     = LW'(new_min);
            judge_next.level_max     = LW'(new_max);
            judge_next.span          = LW'(span_sb);
        end
    end

    // trigger levels
    aksd_trigger_calc u_trigger (
        .clk       (clk),
        .rst_n     (rst_n),
        .judge     (judge_reg),
        .ppm       (ppm),
        .push      (push),
        .push_data (push_data)
    );

    // result buffer
    aksd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop_valid (results.valid),
        .pop_ready (results.ready),
        .pop_data  (results.payload)
    );

    // calibration stays frozen while the key is down
    a_frozen_cal: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !e_oor_reg && cur_pressed)
        |-> (new_min == cur_min) && (new_max == cur_max))
        else $error("min/max changed while key pressed");

    // an uncalibrated sensor never ends up pressed
    a_uncal_released: assert property (@(posedge clk) disable iff (!rst_n)
        (judge_reg.valid && !judge_reg.calibrated)
        |-> !judge_reg.key_down && !judge_reg.press_event)
        else $error("key pressed without calibration");

    // a press event leaves the key down
    a_press_state: assert property (@(posedge clk) disable iff (!rst_n)
        (judge_reg.valid && judge_reg.press_event)
        |-> judge_reg.key_down && !judge_reg.release_event)
        else $error("press event with key released");

    // every delivered result belongs to an accepted request
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> (outstanding_reg != '0))
        else $error("result delivered with nothing outstanding");

endmodule
